// File: src/assert_macros.svh
// Assertion macros used by the checker in skt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a holds in a cycle, so c holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Condition a holds in a cycle, so c holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: src/skt_pkg.sv
// Package with the sizes and state type of the sorted key table.
`default_nettype none
package skt_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 31;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W      = 6;
  localparam int USED_W      = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DECIDE,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_RESULT
  } skt_state_e;
endpackage
`default_nettype wire

// File: src/skt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module skt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/sorted_key_table_find_or_insert.sv
// Top level of the sorted key table: binary search find, shift-up insert.
//
// A request word is taken at a clock edge where start_i is high and busy_o is
// low. busy_o stays high until the result has been shown. The result word is
// on slot_index_o, was_created_o, table_full_o and entries_used_o for exactly
// one cycle, marked by done_o; the receiver cannot stall it.
// The keys live in one RAM with a registered read. Each probe of the binary
// search is a read (ST_SEARCH), then a compare (ST_COMPARE). A found key or a
// refused insert goes from ST_DECIDE straight to ST_RESULT. An insert also
// moves every entry from the slot upward up one place, each by a read
// (ST_SHIFT) and a write (ST_SHIFT_WR), then writes the new key in ST_SHIFT.
// The memory port pair sets this pace.
// A result word is shown in the cycle after the work ends, and a new request
// is taken in the cycle after done_o.
// Reset clears the entry count, so the table starts empty; the RAM needs no
// clearing because only entries below the count are ever used.
`default_nettype none
module sorted_key_table_find_or_insert import skt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [KEY_W-1:0]  request_key_i,
  output logic                   done_o,
  output logic [SLOT_W-1:0]      slot_index_o,
  output logic                   was_created_o,
  output logic                   table_full_o,
  output logic [USED_W-1:0]      entries_used_o
);
  skt_state_e       state_q, state_d;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, lo_q, hi_q, mid_q, ptr_q;
  logic             eq_q, created_q, full_q;
  logic [CNT_W-1:0] mid;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_d = (lo_q < hi_q) ? ST_COMPARE : ST_DECIDE;
      end
      ST_COMPARE: state_d = ST_SEARCH;
      ST_DECIDE: begin
        if (eq_q || count_q == CNT_W'(MAX_ENTRIES)) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        state_d = (ptr_q > lo_q) ? ST_SHIFT_WR : ST_RESULT;
      end
      ST_SHIFT_WR: state_d = ST_SHIFT;
      ST_RESULT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(ptr_q);
    ram_wdata = ram_rdata;
    ram_raddr = IDX_W'(mid);
    case (state_q)
      ST_SHIFT: begin
        ram_raddr = IDX_W'(ptr_q - CNT_W'(1));
        if (ptr_q <= lo_q) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(lo_q);
          ram_wdata = key_q;
        end
      end
      ST_SHIFT_WR: ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      key_q     <= '0;
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      ptr_q     <= '0;
      eq_q      <= 1'b0;
      created_q <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            key_q     <= request_key_i;
            lo_q      <= '0;
            hi_q      <= count_q;
            eq_q      <= 1'b0;
            created_q <= 1'b0;
            full_q    <= 1'b0;
          end
        end
        ST_SEARCH: mid_q <= mid;
        ST_COMPARE: begin
          if (ram_rdata < key_q) begin
            lo_q <= mid_q + CNT_W'(1);
          end else begin
            hi_q <= mid_q;
            eq_q <= (ram_rdata == key_q);
          end
        end
        ST_DECIDE: begin
          ptr_q <= count_q;
          if (!eq_q && count_q == CNT_W'(MAX_ENTRIES)) begin
            full_q <= 1'b1;
          end
        end
        ST_SHIFT: begin
          if (ptr_q <= lo_q) begin
            count_q   <= count_q + CNT_W'(1);
            created_q <= 1'b1;
          end
        end
        ST_SHIFT_WR: ptr_q <= ptr_q - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_o         = (state_q != ST_IDLE);
    done_o         = (state_q == ST_RESULT);
    slot_index_o   = full_q ? '0 : SLOT_W'(lo_q);
    was_created_o  = created_q;
    table_full_o   = full_q;
    entries_used_o = USED_W'(count_q);
  end
endmodule
`default_nettype wire

// File: src/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module skt_checker import skt_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic [KEY_W-1:0]  request_key_i,
  input wire logic              done_o,
  input wire logic [SLOT_W-1:0] slot_index_o,
  input wire logic              was_created_o,
  input wire logic              table_full_o,
  input wire logic [USED_W-1:0] entries_used_o
);
  logic unused_inputs;
  assign unused_inputs = ^{request_key_i, slot_index_o};

  `ASSERT_SAME(a_done_while_busy, clk_i, rst_ni, done_o, busy_o)
  `ASSERT_NEXT(a_accept_sets_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_NEXT(a_done_one_cycle, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_SAME(a_created_not_full, clk_i, rst_ni, done_o && was_created_o,
    !table_full_o && !unused_inputs === !unused_inputs)
  `ASSERT_SAME(a_full_at_capacity, clk_i, rst_ni, done_o && table_full_o,
    entries_used_o == USED_W'(MAX_ENTRIES))
endmodule

bind sorted_key_table_find_or_insert skt_checker u_skt_checker (.*);
`default_nettype wire
